// File: rtl/mexp_pkg.sv
`default_nettype none

package mexp_pkg;

    // Width of every field and configuration register at the ports.
    localparam int FIELD_W = 32;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_EXPONENT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_MODULUS  = 1'b1;

endpackage

`default_nettype wire

// File: rtl/mexp_modmul.sv
`default_nettype none

module mexp_modmul #(
    parameter int W = 32
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire logic [W-1:0] x_in,
    input  wire logic [W-1:0] y_in,
    input  wire logic [W-1:0] m_in,
    output logic      [W-1:0] result,
    output logic              done
);

    // Double-and-add: one multiplier bit per cycle, most significant first.
    localparam int TW = W + 2;
    localparam int CW = (W > 1) ? $clog2(W) : 1;

    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  x_reg, x_next;
    logic [W-1:0]  y_reg, y_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    logic [TW-1:0] sum;
    logic [TW-1:0] m1;
    logic [TW-1:0] m2;
    logic [TW-1:0] diff1;
    logic [TW-1:0] diff2;
    logic [W-1:0]  step;

    // With acc and x below m the sum stays below 3m, so at most two
    // subtractions of m bring it back into range.
    always_comb begin
        m1    = TW'(m_in);
        m2    = {1'b0, m_in, 1'b0};
        sum   = {1'b0, acc_reg, 1'b0} + (y_reg[W-1] ? TW'(x_reg) : '0);
        diff1 = sum - m1;
        diff2 = sum - m2;
        if (sum >= m2) begin
            step = diff2[W-1:0];
        end else if (sum >= m1) begin
            step = diff1[W-1:0];
        end else begin
            step = sum[W-1:0];
        end
    end

    always_comb begin
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            acc_next  = '0;
            x_next    = x_in;
            y_next    = y_in;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            acc_next = step;
            y_next   = {y_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        cnt_reg <= cnt_next;
    end

    assign result = acc_reg;
    assign done   = done_reg;

endmodule

`default_nettype wire

// File: rtl/modular_exponentiation_unit.sv
// Modular exponentiation unit: each input beat carries a base value and the
// output beat returns base^exponent mod modulus, where exponent and modulus come
// from the configuration registers (index 0 and 1) and are cut to WORD_WIDTH
// bits. An exponent of zero returns 1; a zero modulus with a nonzero exponent
// returns 0 with modulus_error set. The block works on one base at a time and
// is ready only while idle. All work runs through one shared modular multiplier
// that handles one multiplier bit per cycle. An item takes one reduction of
// the base, one squaring per exponent bit and one multiplication per set bit.
// The special cases skip the multiplier. The finished result sits in an
// output register, so a new base may be accepted while the previous result
// still waits to be taken.

`default_nettype none

module modular_exponentiation_unit #(
    parameter int WORD_WIDTH = 32
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                cfg_wr_en,
    input  wire logic [mexp_pkg::CFG_INDEX_W-1:0]    cfg_wr_index,
    input  wire logic [mexp_pkg::FIELD_W-1:0]        cfg_wr_data,

    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [mexp_pkg::FIELD_W-1:0]        s_base_value,

    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic      [mexp_pkg::FIELD_W-1:0]        m_power_result,
    output logic                                     m_modulus_error
);

    import mexp_pkg::*;

    localparam int W    = WORD_WIDTH;
    localparam int EW   = $clog2(W);
    localparam int XW   = 64;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_REDUCE   = 3'd1;
    localparam logic [2:0] ST_SQUARE   = 3'd2;
    localparam logic [2:0] ST_MULTIPLY = 3'd3;
    localparam logic [2:0] ST_FINISH   = 3'd4;

    // FIELD_W config regs; user must change only while idle (not enforced).
    logic [FIELD_W-1:0] exponent_reg;
    logic [FIELD_W-1:0] modulus_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exponent_reg <= '0;
            modulus_reg  <= FIELD_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_EXPONENT: exponent_reg <= cfg_wr_data;
                REG_MODULUS:  modulus_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Operands brought to the working width: zero-extended when the word is
    // wider than the field, truncated when it is narrower.
    logic [XW-1:0] exp_ext;
    logic [XW-1:0] mod_ext;
    logic [XW-1:0] base_ext;
    logic [W-1:0]  exp_w;
    logic [W-1:0]  mod_w;
    logic [W-1:0]  base_w;

    assign exp_ext  = XW'(exponent_reg);
    assign mod_ext  = XW'(modulus_reg);
    assign base_ext = XW'(s_base_value);
    assign exp_w    = exp_ext[W-1:0];
    assign mod_w    = mod_ext[W-1:0];
    assign base_w   = base_ext[W-1:0];

    // Sequencer and datapath registers.
    logic [2:0]         state_reg, state_next;
    logic [W-1:0]       base_reg, base_next;
    logic [W-1:0]       r_reg, r_next;
    logic               err_reg, err_next;
    logic [EW-1:0]      ebit_reg, ebit_next;
    logic               m_valid_reg, m_valid_next;
    logic [FIELD_W-1:0] out_result_reg, out_result_next;
    logic               out_err_reg, out_err_next;

    // Shared multiplier hookup.
    logic         mm_start;
    logic [W-1:0] mm_x;
    logic [W-1:0] mm_y;
    logic [W-1:0] mm_result;
    logic         mm_done;
    logic [XW-1:0] r_ext;

    assign r_ext = XW'(r_reg);

    mexp_modmul #(
        .W (W)
    ) u_modmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mm_start),
        .x_in    (mm_x),
        .y_in    (mm_y),
        .m_in    (mod_w),
        .result  (mm_result),
        .done    (mm_done)
    );

    always_comb begin
        state_next      = state_reg;
        base_next       = base_reg;
        r_next          = r_reg;
        err_next        = err_reg;
        ebit_next       = ebit_reg;
        out_result_next = out_result_reg;
        out_err_next    = out_err_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        mm_start        = 1'b0;
        mm_x            = mm_result;
        mm_y            = mm_result;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    ebit_next = EW'(W - 1);
                    if (exp_w == '0) begin
                        r_next     = W'(1);
                        err_next   = 1'b0;
                        state_next = ST_FINISH;
                    end else if (mod_w == '0) begin
                        r_next     = '0;
                        err_next   = 1'b1;
                        state_next = ST_FINISH;
                    end else begin
                        // The running power starts at 1 mod m; the base is
                        // reduced first as 1 * base mod m.
                        r_next     = (mod_w == W'(1)) ? '0 : W'(1);
                        err_next   = 1'b0;
                        mm_start   = 1'b1;
                        mm_x       = W'(1);
                        mm_y       = base_w;
                        state_next = ST_REDUCE;
                    end
                end
            end

            ST_REDUCE: begin
                if (mm_done) begin
                    base_next  = mm_result;
                    mm_start   = 1'b1;
                    mm_x       = r_reg;
                    mm_y       = r_reg;
                    state_next = ST_SQUARE;
                end
            end

            ST_SQUARE: begin
                if (mm_done) begin
                    r_next = mm_result;
                    if (exp_w[ebit_reg]) begin
                        mm_start   = 1'b1;
                        mm_y       = base_reg;
                        state_next = ST_MULTIPLY;
                    end else if (ebit_reg == '0) begin
                        state_next = ST_FINISH;
                    end else begin
                        ebit_next = ebit_reg - 1'b1;
                        mm_start  = 1'b1;
                    end
                end
            end

            ST_MULTIPLY: begin
                if (mm_done) begin
                    r_next = mm_result;
                    if (ebit_reg == '0) begin
                        state_next = ST_FINISH;
                    end else begin
                        ebit_next  = ebit_reg - 1'b1;
                        mm_start   = 1'b1;
                        state_next = ST_SQUARE;
                    end
                end
            end

            ST_FINISH: begin
                // Wait here while the previous result is still unclaimed.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    out_result_next = r_ext[FIELD_W-1:0];
                    out_err_next    = err_reg;
                    state_next      = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        base_reg       <= base_next;
        r_reg          <= r_next;
        err_reg        <= err_next;
        ebit_reg       <= ebit_next;
        out_result_reg <= out_result_next;
        out_err_reg    <= out_err_next;
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_power_result  = out_result_reg;
    assign m_modulus_error = out_err_reg;

endmodule

`default_nettype wire

// File: rtl/mexp_checker.sv
`default_nettype none

module mexp_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_valid,
    input wire logic                         s_ready,
    input wire logic                         m_valid,
    input wire logic                         m_ready,
    input wire logic [mexp_pkg::FIELD_W-1:0] m_power_result,
    input wire logic                         m_modulus_error
);

    // A result beat holds until it is taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_power_result)
                                && $stable(m_modulus_error))
        else $error("result beat changed before it was taken");

    // Accepting a base starts work, so the input side closes.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input still ready right after accepting a base");

    // The error result always carries a zero power.
    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_modulus_error |-> m_power_result == '0)
        else $error("modulus error with a nonzero power result");

    // No result is offered coming out of reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind modular_exponentiation_unit mexp_checker u_mexp_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_power_result  (m_power_result),
    .m_modulus_error (m_modulus_error)
);

`default_nettype wire
